/* rtl/block_mosaic_pixelate_macros.svh */
// Assertion macros for the mosaic pixelate block.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef BLOCK_MOSAIC_PIXELATE_MACROS_SVH
`define BLOCK_MOSAIC_PIXELATE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bmp_pkg.sv */
// Package for the mosaic pixelate block: sizes, register map, shared types.
// No dependencies.
`default_nettype none

package bmp_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int PIX_W = 32;
  localparam int BS_W  = 8;
  localparam int DIM_W = 12;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  // wide enough for any dimension value and for MAX_WIDTH / MAX_HEIGHT themselves
  localparam int CMP_W = ((DIM_W > COL_W) ? DIM_W : ((COL_W > ROW_W) ? COL_W : ROW_W)) + 1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [BS_W-1:0]  BLOCK_SIZE_RST   = BS_W'(50);
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = DIM_W'(640);
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(480);

  typedef enum logic [1:0] {
    REG_BLOCK_SIZE   = 2'd0,
    REG_IMAGE_WIDTH  = 2'd1,
    REG_IMAGE_HEIGHT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [BS_W-1:0]  block_size;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  // where a word's output pixel comes from
  typedef enum logic [1:0] {
    SRC_HOLD,        // inside a block: repeat current block pixel
    SRC_TOP_NEW,     // top-left of a block on its first row: the input itself
    SRC_TOP_STORED   // top-left of a block on a later row: from the store
  } src_e;

  typedef struct packed {
    src_e src;
    logic row_end;
    logic frame_end;
  } scan_ctl_t;

endpackage

`default_nettype wire

/* rtl/block_mosaic_pixelate.sv */
// Mosaic pixelate: takes 32-bit BGRA pixels in raster order and returns one
// word per input word, each the top-left pixel of the square block (edge
// block_size, 0 acting as 1) that holds its position; blocks on the right and
// bottom edges are cut short. A word is taken every clock unless output stalls;
// each result goes through stage 1, then the output register, so input keeps
// flowing while a result waits. Throughput is one pixel per clock while the
// sink keeps up. The block column store holds one 32-bit entry per block
// column, with registered read data, and has no clear after reset: it is filled
// on each block row's first line and read on its later lines, which is
// guaranteed whenever frames start with s_axis_tuser set and the size registers
// are written only between frames. Row and frame end are flagged on the output
// (tlast, tuser). Registers: 0x0 block_size, 0x4 image_width, 0x8 image_height.
// Depends on bmp_pkg, bmp_regs, bmp_scan, bmp_ram, bmp_out and the macro header.
`default_nettype none

`include "block_mosaic_pixelate_macros.svh"

module block_mosaic_pixelate
  import bmp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // input stream
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [PIX_W-1:0]   s_axis_tdata,   // [31:0] pixel_in
  input  wire logic               s_axis_tuser,   // [0] frame_start
  // output stream
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [PIX_W-1:0]   m_axis_tdata,   // [31:0] pixel_out
  output logic                    m_axis_tlast,   // row_end
  output logic                    m_axis_tuser    // [0] frame_end
);

  cfg_t             cfg;
  logic             accept;
  logic             advance;
  logic             ram_we, ram_re;
  logic [COL_W-1:0] ram_addr;
  logic [PIX_W-1:0] ram_rdata;
  logic             s1_valid;
  logic [PIX_W-1:0] s1_pixel;
  scan_ctl_t        s1_ctl;

  bmp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage 1 frees up whenever its word moves on to the output register
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  bmp_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .advance_i     (advance),
    .pixel_i       (s_axis_tdata),
    .frame_start_i (s_axis_tuser),
    .ram_we_o      (ram_we),
    .ram_re_o      (ram_re),
    .ram_addr_o    (ram_addr),
    .s1_valid_o    (s1_valid),
    .s1_pixel_o    (s1_pixel),
    .s1_ctl_o      (s1_ctl)
  );

  // block column store; read data holds while stage 1 is stalled (read only on accept)
  bmp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  bmp_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid),
    .s1_pixel_i      (s1_pixel),
    .s1_ctl_i        (s1_ctl),
    .ram_rdata_i     (ram_rdata),
    .advance_o       (advance),
    .out_valid_o     (m_axis_tvalid),
    .out_pixel_o     (m_axis_tdata),
    .out_row_end_o   (m_axis_tlast),
    .out_frame_end_o (m_axis_tuser),
    .out_ready_i     (m_axis_tready)
  );

  // frame end only ever comes with a row end
  `BMP_ASSERT_NOW(a_fend_is_rend, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "frame end without row end")
  // store is never written and read in the same cycle
  `BMP_ASSERT_NOW(a_store_one_access, ram_we, !ram_re, "store written and read together")
  // first word of a frame takes its own pixel as block pixel
  `BMP_ASSERT_NEXT(a_fstart_new_top, accept && s_axis_tuser, s1_valid && (s1_ctl.src == SRC_TOP_NEW), "frame start not a new block top")
  // a stalled stage 1 keeps its word
  `BMP_ASSERT_NEXT(a_s1_holds, s1_valid && !advance, s1_valid && $stable(s1_ctl), "stage 1 word lost during stall")

endmodule

`default_nettype wire

/* rtl/bmp_ram.sv */
// Generic single-clock RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none

module bmp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/bmp_regs.sv */
// APB register file: block size, image width, image height.
// Depends on bmp_pkg.
`default_nettype none

module bmp_regs
  import bmp_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_BLOCK_SIZE:   cfg_d.block_size   = pwdata[BS_W-1:0];
        REG_IMAGE_WIDTH:  cfg_d.image_width  = pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_d.image_height = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BLOCK_SIZE:   prdata = PDATA_W'(cfg_q.block_size);
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(cfg_q.image_width);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(cfg_q.image_height);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size   <= BLOCK_SIZE_RST;
      cfg_q.image_width  <= IMAGE_WIDTH_RST;
      cfg_q.image_height <= IMAGE_HEIGHT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/bmp_scan.sv */
// Raster position counters, store write/read issue, and the first pipeline stage.
// Depends on bmp_pkg.
`default_nettype none

module bmp_scan
  import bmp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cfg_t             cfg_i,
  input  wire logic             accept_i,
  input  wire logic             advance_i,
  input  wire logic [PIX_W-1:0] pixel_i,
  input  wire logic             frame_start_i,
  output logic                  ram_we_o,
  output logic                  ram_re_o,
  output logic      [COL_W-1:0] ram_addr_o,
  output logic                  s1_valid_o,
  output logic      [PIX_W-1:0] s1_pixel_o,
  output scan_ctl_t             s1_ctl_o
);

  logic [COL_W-1:0] col_q, col_d, col_e;
  logic [ROW_W-1:0] row_q, row_d, row_e;
  logic [BS_W-1:0]  cib_q, cib_d, cib_e;
  logic [BS_W-1:0]  rib_q, rib_d, rib_e;
  logic [COL_W-1:0] bci_q, bci_d, bci_e;

  logic [BS_W-1:0]  bs_eff;
  logic [CMP_W-1:0] w_ext, h_ext, last_col, last_row;
  scan_ctl_t        ctl;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pixel_q;
  scan_ctl_t        s1_ctl_q;

  assign bs_eff = (cfg_i.block_size == '0) ? BS_W'(1) : cfg_i.block_size;
  assign w_ext  = CMP_W'(cfg_i.image_width);
  assign h_ext  = CMP_W'(cfg_i.image_height);

  always_comb begin
    if (w_ext == '0)                    last_col = '0;
    else if (w_ext > CMP_W'(MAX_WIDTH)) last_col = CMP_W'(MAX_WIDTH - 1);
    else                                last_col = w_ext - CMP_W'(1);
    if (h_ext == '0)                     last_row = '0;
    else if (h_ext > CMP_W'(MAX_HEIGHT)) last_row = CMP_W'(MAX_HEIGHT - 1);
    else                                 last_row = h_ext - CMP_W'(1);
  end

  // frame start clears the counters before this word is placed
  assign col_e = frame_start_i ? '0 : col_q;
  assign row_e = frame_start_i ? '0 : row_q;
  assign cib_e = frame_start_i ? '0 : cib_q;
  assign rib_e = frame_start_i ? '0 : rib_q;
  assign bci_e = frame_start_i ? '0 : bci_q;

  always_comb begin
    if (cib_e != '0)      ctl.src = SRC_HOLD;
    else if (rib_e == '0) ctl.src = SRC_TOP_NEW;
    else                  ctl.src = SRC_TOP_STORED;
    ctl.row_end   = CMP_W'(col_e) >= last_col;
    ctl.frame_end = ctl.row_end && (CMP_W'(row_e) >= last_row);
  end

  always_comb begin
    col_d = col_e;
    row_d = row_e;
    cib_d = cib_e;
    rib_d = rib_e;
    bci_d = bci_e;
    if (ctl.row_end) begin
      col_d = '0;
      cib_d = '0;
      bci_d = '0;
      if (ctl.frame_end) begin
        row_d = '0;
        rib_d = '0;
      end else begin
        row_d = row_e + ROW_W'(1);
        rib_d = (({1'b0, rib_e} + (BS_W+1)'(1)) >= {1'b0, bs_eff}) ? '0 : rib_e + BS_W'(1);
      end
    end else begin
      col_d = col_e + COL_W'(1);
      if (({1'b0, cib_e} + (BS_W+1)'(1)) >= {1'b0, bs_eff}) begin
        cib_d = '0;
        bci_d = bci_e + COL_W'(1);
      end else begin
        cib_d = cib_e + BS_W'(1);
      end
    end
  end

  // Writes land on a block's first row, reads on its later rows, so a read
  // always follows the write of its entry by at least one accepted word.
  assign ram_we_o   = accept_i && (ctl.src == SRC_TOP_NEW);
  assign ram_re_o   = accept_i && (ctl.src == SRC_TOP_STORED);
  assign ram_addr_o = bci_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      cib_q      <= '0;
      rib_q      <= '0;
      bci_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_ctl_q   <= '0;
    end else begin
      if (accept_i) begin
        col_q    <= col_d;
        row_q    <= row_d;
        cib_q    <= cib_d;
        rib_q    <= rib_d;
        bci_q    <= bci_d;
        s1_ctl_q <= ctl;
      end
      if (accept_i)       s1_valid_q <= 1'b1;
      else if (advance_i) s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_pixel_q <= pixel_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_pixel_o = s1_pixel_q;
  assign s1_ctl_o   = s1_ctl_q;

endmodule

`default_nettype wire

/* rtl/bmp_out.sv */
// Second stage: picks the block pixel, keeps the current one, drives the output register.
// Depends on bmp_pkg.
`default_nettype none

module bmp_out
  import bmp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s1_valid_i,
  input  wire logic [PIX_W-1:0] s1_pixel_i,
  input  wire scan_ctl_t        s1_ctl_i,
  input  wire logic [PIX_W-1:0] ram_rdata_i,
  output logic                  advance_o,
  output logic                  out_valid_o,
  output logic      [PIX_W-1:0] out_pixel_o,
  output logic                  out_row_end_o,
  output logic                  out_frame_end_o,
  input  wire logic             out_ready_i
);

  logic [PIX_W-1:0] cur_q, cur_d;
  logic             out_valid_q;
  logic [PIX_W-1:0] out_pixel_q;
  logic             out_row_end_q, out_frame_end_q;

  assign advance_o = s1_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    case (s1_ctl_i.src)
      SRC_TOP_NEW:    cur_d = s1_pixel_i;
      SRC_TOP_STORED: cur_d = ram_rdata_i;
      SRC_HOLD:       cur_d = cur_q;
      default:        cur_d = cur_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q           <= '0;
      out_valid_q     <= 1'b0;
      out_row_end_q   <= 1'b0;
      out_frame_end_q <= 1'b0;
    end else begin
      if (advance_o) begin
        cur_q           <= cur_d;
        out_valid_q     <= 1'b1;
        out_row_end_q   <= s1_ctl_i.row_end;
        out_frame_end_q <= s1_ctl_i.frame_end;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      out_pixel_q <= cur_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_pixel_o     = out_pixel_q;
  assign out_row_end_o   = out_row_end_q;
  assign out_frame_end_o = out_frame_end_q;

endmodule

`default_nettype wire

/* bench/block_mosaic_pixelate_test.sv */
// Self-checking bench for block_mosaic_pixelate: a directed table, then random frames,
// with every output word checked against an in-bench mosaic predictor.
// Depends on bmp_pkg and the block_mosaic_pixelate RTL only.
`timescale 1ns / 100ps

module block_mosaic_pixelate_test
  import bmp_pkg::*;
();

  localparam int RAND_ITEMS    = 1700;  // random words, large phases included
  localparam int BIG_ITEMS     = 200;   // words sent in each large phase
  localparam int QUIET_ITEMS   = 200;   // tail of the run with no idling
  localparam int HOLD_CYCLES   = 48;    // long sink hold-off to back the block up
  localparam int MAX_ERR_LINES = 40;

  // one output word as the block should produce it
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             frame_end;
  } mosaic_word_t;

  // one input word; typed marks a hand-written expectation that replaces the prediction
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             first;
    logic             typed;
    mosaic_word_t     want;
  } pix_item_t;

  typedef enum logic {ROW_PIX, ROW_CFG} dir_kind_e;

  typedef struct packed {
    dir_kind_e        kind;
    reg_idx_e         idx;
    logic [31:0]      val;
    logic [PIX_W-1:0] pix;
    logic             first;
    logic             typed;
    mosaic_word_t     want;
  } dir_row_t;

  // Directed table. Register rows are written with the block drained.
  // Covers reset sizes, zero block size and clamped zero sizes, a bs=1 frame that fills
  // store entries 0..7, then a 2-pixel block frame cut mid-frame by lowering block size,
  // width and height (counters past their end), and a wrap into the next frame
  // with no frame start.
  localparam dir_row_t DIR_TAB [36] = '{
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h11223344, 1'b1, 1'b1, '{32'h11223344, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'hFFFFFFFF, 1'b0, 1'b1, '{32'h11223344, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h00000000, 1'b0, 1'b1, '{32'h11223344, 1'b0, 1'b0}},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd0, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd0, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd0, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'hA5A5A5A5, 1'b1, 1'b1, '{32'hA5A5A5A5, 1'b1, 1'b1}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h5A5A5A5A, 1'b0, 1'b1, '{32'h5A5A5A5A, 1'b1, 1'b1}},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd1, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd8, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd1, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h00000001, 1'b1, 1'b1, '{32'h00000001, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h80000000, 1'b0, 1'b1, '{32'h80000000, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h7FFFFFFF, 1'b0, 1'b1, '{32'h7FFFFFFF, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'hFEDCBA98, 1'b0, 1'b1, '{32'hFEDCBA98, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h01234567, 1'b0, 1'b1, '{32'h01234567, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'hC0FFEE00, 1'b0, 1'b1, '{32'hC0FFEE00, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h0000FFFF, 1'b0, 1'b1, '{32'h0000FFFF, 1'b0, 1'b0}},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'hFFFF0000, 1'b0, 1'b1, '{32'hFFFF0000, 1'b1, 1'b1}},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd2, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd6, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd3, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h10101010, 1'b1, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h20202020, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h30303030, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h40404040, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h50505050, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h60606060, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h70707070, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_BLOCK_SIZE,   32'd1, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h80808080, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'h90909090, 1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_WIDTH,  32'd2, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_HEIGHT, 32'd1, 32'd0,        1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'hA0A0A0A0, 1'b0, 1'b0, '0},
    '{ROW_PIX, REG_BLOCK_SIZE,   32'd0, 32'hB0B0B0B0, 1'b0, 1'b0, '0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [PIX_W-1:0]   s_axis_tdata;   // [31:0] pixel_in
  logic               s_axis_tuser;   // [0] frame_start
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [PIX_W-1:0]   m_axis_tdata;   // [31:0] pixel_out
  logic               m_axis_tlast;   // row_end
  logic               m_axis_tuser;   // [0] frame_end

  // predictor copy of the registers and scan state
  logic [BS_W-1:0]  cfg_bs = BLOCK_SIZE_RST;
  logic [DIM_W-1:0] cfg_w  = IMAGE_WIDTH_RST;
  logic [DIM_W-1:0] cfg_h  = IMAGE_HEIGHT_RST;
  logic [PIX_W-1:0] top_mem [MAX_WIDTH];   // top-left pixel per block column
  logic [PIX_W-1:0] cur_pix = '0;
  logic [COL_W-1:0] col_cnt = '0;
  logic [COL_W-1:0] blk_col = '0;
  logic [ROW_W-1:0] row_cnt = '0;
  logic [BS_W-1:0]  col_off = '0;
  logic [BS_W-1:0]  row_off = '0;

  pix_item_t    offered_q [$];   // words put on the input bus, oldest first
  mosaic_word_t mosaic_exp_q [$];
  int           err_cnt = 0;
  int           src_gap_pct = 0;     // chance of an input gap before a word
  int           sink_stall_pct = 0;  // chance per cycle of a sink stall burst
  bit           hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  block_mosaic_pixelate u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  task automatic report_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= MAX_ERR_LINES) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Next mosaic word for one accepted pixel; advances the scan state.
  function automatic mosaic_word_t mosaic_predict(input logic [PIX_W-1:0] pix,
                                                  input logic first);
    mosaic_word_t r;
    int bs_eff, w_eff, h_eff;
    bs_eff = (cfg_bs == '0) ? 1 : int'(cfg_bs);
    w_eff  = (cfg_w == '0) ? 1 : ((int'(cfg_w) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_w));
    h_eff  = (cfg_h == '0) ? 1 : ((int'(cfg_h) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_h));
    if (first) begin
      col_cnt = '0;
      row_cnt = '0;
      col_off = '0;
      row_off = '0;
      blk_col = '0;
    end
    // top-left of a block: first block row takes the pixel, later rows the stored one
    if (col_off == '0) begin
      if (row_off == '0) begin
        cur_pix = pix;
        top_mem[blk_col] = pix;
      end else begin
        cur_pix = top_mem[blk_col];
      end
    end
    r.pix       = cur_pix;
    r.row_end   = int'(col_cnt) >= w_eff - 1;
    r.frame_end = r.row_end && (int'(row_cnt) >= h_eff - 1);
    if (r.row_end) begin
      col_cnt = '0;
      col_off = '0;
      blk_col = '0;
      if (r.frame_end) begin
        row_cnt = '0;
        row_off = '0;
      end else begin
        row_cnt = row_cnt + 1'b1;
        row_off = (int'(row_off) + 1 >= bs_eff) ? '0 : row_off + 1'b1;
      end
    end else begin
      col_cnt = col_cnt + 1'b1;
      if (int'(col_off) + 1 >= bs_eff) begin
        col_off = '0;
        blk_col = blk_col + 1'b1;
      end else begin
        col_off = col_off + 1'b1;
      end
    end
    return r;
  endfunction

  // One APB transfer: setup, access, then psel drops at the edge that completes it.
  task automatic apb_cycle(input reg_idx_e idx, input logic wr, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(int'(idx) * 4);
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register write plus readback; the predictor takes the value at once since the
  // block is drained whenever this runs.
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] held;
    logic [31:0] mask;
    apb_cycle(idx, 1'b1, val, rd);
    case (idx)
      REG_BLOCK_SIZE: begin
        cfg_bs = val[BS_W-1:0];
        held   = 32'(cfg_bs);
        mask   = 32'((1 << BS_W) - 1);
      end
      REG_IMAGE_WIDTH: begin
        cfg_w = val[DIM_W-1:0];
        held  = 32'(cfg_w);
        mask  = 32'((1 << DIM_W) - 1);
      end
      default: begin
        cfg_h = val[DIM_W-1:0];
        held  = 32'(cfg_h);
        mask  = 32'((1 << DIM_W) - 1);
      end
    endcase
    apb_cycle(idx, 1'b0, '0, rd);
    if ((rd & mask) !== held)
      report_mismatch($sformatf("%s reads 0x%0h, wrote 0x%0h", idx.name(), rd, held));
  endtask

  // Offer one word, maybe after a short gap, and return at the edge that takes it.
  task automatic send_pixel(input pix_item_t item);
    if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= item.pix;
    s_axis_tuser  <= item.first;
    offered_q.push_back(item);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every offered word is taken and every expected word
  // has come out of the block.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (offered_q.size() != 0 || mosaic_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sink side: random stall bursts, plus one long hold-off on request.
  initial begin : sink_drive
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (sink_stall_pct != 0 && $urandom_range(1, 100) <= sink_stall_pct) begin
        stall_left = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Both handshakes are sampled here: inputs feed the predictor, outputs get checked.
  always @(posedge clk_i) begin : stream_check
    pix_item_t    acc;
    mosaic_word_t got;
    mosaic_word_t want;
    if (rst_ni === 1'b1) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (offered_q.size() == 0) begin
          report_mismatch("input word taken while none offered");
        end else begin
          acc  = offered_q.pop_front();
          want = mosaic_predict(acc.pix, acc.first);
          if (acc.typed) want = acc.want;
          mosaic_exp_q.push_back(want);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{pix: m_axis_tdata, row_end: m_axis_tlast, frame_end: m_axis_tuser};
        if (mosaic_exp_q.size() == 0) begin
          report_mismatch($sformatf("output word 0x%08h with nothing expected", got.pix));
        end else begin
          want = mosaic_exp_q.pop_front();
          if (got.pix !== want.pix)
            report_mismatch($sformatf("pixel 0x%08h, want 0x%08h", got.pix, want.pix));
          if (got.row_end !== want.row_end)
            report_mismatch($sformatf("row end %b, want %b", got.row_end, want.row_end));
          if (got.frame_end !== want.frame_end)
            report_mismatch($sformatf("frame end %b, want %b",
                                      got.frame_end, want.frame_end));
        end
      end
    end
  end

  // Limit: far beyond the slowest correct run (about 1.7k words at worst-case idling).
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    int          sent_items;
    int          n_frames;
    int          frame_len;
    int          w_eff;
    int          h_eff;
    logic [31:0] bs_val;
    logic [31:0] w_val;
    logic [31:0] h_val;
    logic        first;
    bit          big;

    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, with light idling on both sides
    src_gap_pct    = 20;
    sink_stall_pct = 20;
    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(DIR_TAB[i].idx, DIR_TAB[i].val);
      end else begin
        send_pixel('{DIR_TAB[i].pix, DIR_TAB[i].first, DIR_TAB[i].typed, DIR_TAB[i].want});
      end
    end

    // Random phases: fresh sizes, then a few frames. Each phase starts with a frame
    // start so the block column store is always filled before it is read. Phases 3
    // and 7 are the large ones that set width, then height, past the clamp; they send
    // only the first BIG_ITEMS words of their frame.
    phase      = 0;
    sent_items = 0;
    while (sent_items < RAND_ITEMS || phase <= 7) begin
      big = (phase == 3) || (phase == 7);
      case ($urandom_range(0, 9))
        0:       bs_val = 32'd0;
        1:       bs_val = 32'd255;
        2:       bs_val = $urandom_range(9, 254);
        default: bs_val = $urandom_range(1, 8);
      endcase
      if (phase == 3) begin
        w_val = 32'd4095;
        h_val = 32'd1;
      end else if (phase == 7) begin
        w_val = 32'd1;
        h_val = 32'd4095;
      end else if (phase == 1) begin
        w_val = $urandom_range(8, 24);
        h_val = $urandom_range(2, 8);
      end else begin
        w_val = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 24));
        h_val = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 8));
      end
      wait_idle();
      cfg_write(REG_BLOCK_SIZE, bs_val);
      cfg_write(REG_IMAGE_WIDTH, w_val);
      cfg_write(REG_IMAGE_HEIGHT, h_val);
      w_eff = (w_val == 0) ? 1 : ((w_val > MAX_WIDTH) ? MAX_WIDTH : int'(w_val));
      h_eff = (h_val == 0) ? 1 : ((h_val > MAX_HEIGHT) ? MAX_HEIGHT : int'(h_val));

      // some phases run without idling at all
      case ($urandom_range(0, 2))
        0:       src_gap_pct = 0;
        1:       src_gap_pct = 10;
        default: src_gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       sink_stall_pct = 0;
        1:       sink_stall_pct = 15;
        default: sink_stall_pct = 35;
      endcase
      // long sink hold-off while the source keeps offering: the block must stall input
      if (phase == 1) begin
        src_gap_pct = 0;
        hold_req    = 1'b1;
      end

      n_frames = big ? 1 : $urandom_range(1, 3);
      for (int f = 0; f < n_frames; f++) begin
        frame_len = w_eff * h_eff;
        if (big) frame_len = BIG_ITEMS;
        // broken frame: cut short, the next one picks up mid-frame or restarts
        if (!big && phase != 1 && $urandom_range(0, 5) == 0)
          frame_len = $urandom_range(1, frame_len);
        for (int k = 0; k < frame_len; k++) begin
          first = (k == 0) && (f == 0 || $urandom_range(0, 1) == 1);
          // stray frame start inside a frame
          if (!big && k != 0 && $urandom_range(0, 199) == 0) first = 1'b1;
          if (sent_items >= RAND_ITEMS - QUIET_ITEMS) begin
            src_gap_pct    = 0;
            sink_stall_pct = 0;
          end
          send_pixel('{$urandom, first, 1'b0, '0});
          sent_items++;
        end
      end
      phase++;
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
